FILE: src/vcpi_pkg.sv
// shared types and constants of the video chip port interface
package vcpi_pkg;

  localparam int unsigned ADDR_W = 14;

  // host access kinds
  typedef enum logic [2:0] {
    FUNC_CTRL_WR   = 3'd0,
    FUNC_DATA_WR   = 3'd1,
    FUNC_STATUS_RD = 3'd2,
    FUNC_DATA_RD   = 3'd3,
    FUNC_LINE_TICK = 3'd4,
    FUNC_COUNT_RD  = 3'd5
  } func_t;

  // access code from the second control byte
  localparam logic [1:0] CODE_VRAM_RD = 2'd0;
  localparam logic [1:0] CODE_VRAM_WR = 2'd1;
  localparam logic [1:0] CODE_REG     = 2'd2;
  localparam logic [1:0] CODE_CRAM    = 2'd3;

  // scanline mapping constants
  localparam logic [8:0] VB_LINE_TALL     = 9'd224;
  localparam logic [8:0] VB_LINE_SHORT    = 9'd192;
  localparam logic [8:0] LAST_DIRECT_TALL = 9'h0EA;
  localparam logic [8:0] LAST_DIRECT_SHORT = 9'h0DA;
  localparam logic [7:0] JUMP_FROM_TALL   = 8'hEB;
  localparam logic [7:0] JUMP_FROM_SHORT  = 8'hDB;
  localparam logic [7:0] JUMP_TO_TALL     = 8'hE5;
  localparam logic [7:0] JUMP_TO_SHORT    = 8'hD5;
  localparam logic [7:0] STATUS_VBLANK    = 8'h80;

  // one memory port request from the core
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

FILE: src/vcpi_ram.sv
// byte-wide memory with registered read and a clearing sweep after reset
module vcpi_ram #(
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [7:0]               wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [7:0]               rdata,
  output logic                     busy
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic [7:0]    mem [DEPTH];
  logic [AW-1:0] clr_cnt_r;
  logic          clr_busy_r;
  logic [7:0]    rdata_r;

  // clearing sweep, one entry a cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r  <= '0;
      clr_busy_r <= 1'b1;
    end else if (clr_busy_r) begin
      clr_cnt_r <= clr_cnt_r + AW'(1);
      if (clr_cnt_r == AW'(DEPTH - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // write port, sweep has priority
  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_cnt_r] <= 8'h00;
    end else if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, held between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;
  assign busy  = clr_busy_r;

endmodule

FILE: src/vcpi_core.sv
// port state, access decode and result register
module vcpi_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              mem_busy,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        in_func,
  input  logic [7:0]        in_wdata,
  input  logic [8:0]        in_scan_line,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_rdata,
  output logic              out_irq,
  output vcpi_pkg::mem_req_t vram_req,
  output vcpi_pkg::mem_req_t cram_req,
  input  logic [7:0]        vram_q,
  input  logic [7:0]        cram_q
);

  typedef enum logic [1:0] {
    PF_NONE,
    PF_VRAM,
    PF_CRAM
  } pf_src_t;

  // input register
  logic       in_v_r;
  logic [2:0] func_r;
  logic [7:0] wdata_r;
  logic [8:0] line_r;

  // port state
  logic [vcpi_pkg::ADDR_W-1:0] addr_r, addr_nxt;
  logic [1:0] code_r, code_nxt;
  logic       pend_r, pend_nxt;
  logic [7:0] rbuf_r, rbuf_nxt, rbuf_eff;
  pf_src_t    pf_r, pf_nxt;
  logic [7:0] status_r, status_nxt;
  logic       irq_r, irq_nxt;
  logic [7:0] lc_r, lc_nxt;
  logic [7:0] mode_r [16];
  logic       mode_we;
  logic [3:0] mode_idx;

  // output register
  logic       out_v_r;
  logic [7:0] rdata_r, rdata_nxt;
  logic       oirq_r;

  logic       fire;
  logic       tall;
  logic [8:0] vb_line, last_direct;
  logic [7:0] jump_from, jump_to;
  logic [vcpi_pkg::ADDR_W-1:0] addr_inc, addr_ctrl;

  assign fire     = in_v_r && (!out_v_r || out_ready);
  assign in_ready = !mem_busy && (!in_v_r || fire);

  // read buffer, taking a prefetch issued by the previous executed transaction
  always_comb begin
    case (pf_r)
      PF_VRAM: rbuf_eff = vram_q;
      PF_CRAM: rbuf_eff = cram_q;
      default: rbuf_eff = rbuf_r;
    endcase
  end

  // line mode selection
  assign tall        = mode_r[0][2] && mode_r[1][4];
  assign vb_line     = tall ? vcpi_pkg::VB_LINE_TALL : vcpi_pkg::VB_LINE_SHORT;
  assign last_direct = tall ? vcpi_pkg::LAST_DIRECT_TALL : vcpi_pkg::LAST_DIRECT_SHORT;
  assign jump_from   = tall ? vcpi_pkg::JUMP_FROM_TALL : vcpi_pkg::JUMP_FROM_SHORT;
  assign jump_to     = tall ? vcpi_pkg::JUMP_TO_TALL : vcpi_pkg::JUMP_TO_SHORT;

  assign addr_inc  = addr_r + vcpi_pkg::ADDR_W'(1);
  assign addr_ctrl = {wdata_r[5:0], addr_r[7:0]};

  // access decode, memory requests only on an executing transaction
  always_comb begin
    addr_nxt   = addr_r;
    code_nxt   = code_r;
    pend_nxt   = pend_r;
    rbuf_nxt   = rbuf_eff;
    pf_nxt     = PF_NONE;
    status_nxt = status_r;
    irq_nxt    = irq_r;
    lc_nxt     = lc_r;
    mode_we    = 1'b0;
    mode_idx   = wdata_r[3:0];
    rdata_nxt  = 8'h00;
    vram_req   = '0;
    cram_req   = '0;
    if (fire) begin
      case (func_r)
        vcpi_pkg::FUNC_CTRL_WR: begin
          if (pend_r) begin
            addr_nxt = addr_ctrl;
            code_nxt = wdata_r[7:6];
            pend_nxt = 1'b0;
            if (wdata_r[7:6] == vcpi_pkg::CODE_REG) begin
              mode_we = 1'b1;
            end else if (wdata_r[7:6] == vcpi_pkg::CODE_CRAM) begin
              cram_req.re    = 1'b1;
              cram_req.raddr = addr_ctrl;
              pf_nxt         = PF_CRAM;
            end else begin
              vram_req.re    = 1'b1;
              vram_req.raddr = addr_ctrl;
              pf_nxt         = PF_VRAM;
            end
          end else begin
            addr_nxt = {addr_r[vcpi_pkg::ADDR_W-1:8], wdata_r};
            pend_nxt = 1'b1;
          end
        end
        vcpi_pkg::FUNC_DATA_WR: begin
          pend_nxt = 1'b0;
          rbuf_nxt = wdata_r;
          if (code_r != vcpi_pkg::CODE_REG) begin
            if (code_r == vcpi_pkg::CODE_CRAM) begin
              cram_req.we    = 1'b1;
              cram_req.waddr = addr_r;
              cram_req.wdata = wdata_r;
            end else begin
              vram_req.we    = 1'b1;
              vram_req.waddr = addr_r;
              vram_req.wdata = wdata_r;
            end
            addr_nxt = addr_inc;
          end
        end
        vcpi_pkg::FUNC_STATUS_RD: begin
          pend_nxt   = 1'b0;
          rdata_nxt  = status_r;
          status_nxt = 8'h00;
          irq_nxt    = 1'b0;
        end
        vcpi_pkg::FUNC_DATA_RD: begin
          pend_nxt  = 1'b0;
          rdata_nxt = rbuf_eff;
          if (code_r != vcpi_pkg::CODE_REG) begin
            addr_nxt = addr_inc;
            if (code_r == vcpi_pkg::CODE_CRAM) begin
              cram_req.re    = 1'b1;
              cram_req.raddr = addr_inc;
              pf_nxt         = PF_CRAM;
            end else begin
              vram_req.re    = 1'b1;
              vram_req.raddr = addr_inc;
              pf_nxt         = PF_VRAM;
            end
          end
        end
        vcpi_pkg::FUNC_LINE_TICK: begin
          if (line_r == vb_line) begin
            if (mode_r[1][5]) begin
              irq_nxt = 1'b1;
            end
            status_nxt = status_r | vcpi_pkg::STATUS_VBLANK;
          end
          if (line_r <= last_direct) begin
            lc_nxt = line_r[7:0];
          end else begin
            lc_nxt = line_r[7:0] - jump_from + jump_to;
          end
        end
        vcpi_pkg::FUNC_COUNT_RD: begin
          rdata_nxt = lc_r;
        end
        default: begin
        end
      endcase
    end
  end

  // input register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  // input register payload
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      func_r  <= in_func;
      wdata_r <= in_wdata;
      line_r  <= in_scan_line;
    end
  end

  // port state update on each executed transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r   <= '0;
      code_r   <= '0;
      pend_r   <= 1'b0;
      rbuf_r   <= 8'h00;
      pf_r     <= PF_NONE;
      status_r <= 8'h00;
      irq_r    <= 1'b0;
      lc_r     <= 8'h00;
      for (int i = 0; i < 16; i++) begin
        mode_r[i] <= 8'h00;
      end
    end else if (fire) begin
      addr_r   <= addr_nxt;
      code_r   <= code_nxt;
      pend_r   <= pend_nxt;
      rbuf_r   <= rbuf_nxt;
      pf_r     <= pf_nxt;
      status_r <= status_nxt;
      irq_r    <= irq_nxt;
      lc_r     <= lc_nxt;
      if (mode_we) begin
        mode_r[mode_idx] <= addr_r[7:0];
      end
    end
  end

  // result register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (fire) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (fire) begin
      rdata_r <= rdata_nxt;
      oirq_r  <= irq_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_rdata = rdata_r;
  assign out_irq   = oirq_r;

endmodule

FILE: src/video_chip_port_interface_top.sv
// An accepted transaction is held in the input register, executes once the result register
// is free and writes its result there. Throughput: one transaction per cycle unless a
// memory sweep or a held result stalls it; a prefetch lands in the video or colour memory
// read register and is forwarded. Reset: synchronous, active low; all port state clears
// at once, then a clearing sweep writes zero to every memory entry, with in_ready low.
module video_chip_port_interface_top #(
  parameter int unsigned VRAM_DEPTH = 16384,
  parameter int unsigned CRAM_DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_func,
  input  logic [7:0] in_wdata,
  input  logic [8:0] in_scan_line,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_rdata,
  output logic       out_irq
);

  localparam int unsigned VA_W = $clog2(VRAM_DEPTH);
  localparam int unsigned CA_W = $clog2(CRAM_DEPTH);

  vcpi_pkg::mem_req_t vram_req, cram_req;
  logic [7:0] vram_q, cram_q;
  logic       vram_busy, cram_busy;

  // port core
  vcpi_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .mem_busy     (vram_busy | cram_busy),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_func      (in_func),
    .in_wdata     (in_wdata),
    .in_scan_line (in_scan_line),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_rdata    (out_rdata),
    .out_irq      (out_irq),
    .vram_req     (vram_req),
    .cram_req     (cram_req),
    .vram_q       (vram_q),
    .cram_q       (cram_q)
  );

  // video memory
  vcpi_ram #(
    .DEPTH (VRAM_DEPTH)
  ) u_vram (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (vram_req.we),
    .waddr (vram_req.waddr[VA_W-1:0]),
    .wdata (vram_req.wdata),
    .re    (vram_req.re),
    .raddr (vram_req.raddr[VA_W-1:0]),
    .rdata (vram_q),
    .busy  (vram_busy)
  );

  // colour memory
  vcpi_ram #(
    .DEPTH (CRAM_DEPTH)
  ) u_cram (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (cram_req.we),
    .waddr (cram_req.waddr[CA_W-1:0]),
    .wdata (cram_req.wdata),
    .re    (cram_req.re),
    .raddr (cram_req.raddr[CA_W-1:0]),
    .rdata (cram_q),
    .busy  (cram_busy)
  );

endmodule

FILE: tb/vcpi_port_checker.sv
// transaction monitor, port behavior predictor and result comparator for the video chip port
module vcpi_port_checker #(
  parameter int unsigned VRAM_DEPTH = 16384,
  parameter int unsigned CRAM_DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [2:0] in_func,
  input  logic [7:0] in_wdata,
  input  logic [8:0] in_scan_line,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_rdata,
  input  logic       out_irq,
  output int         fail_cnt,
  output int         pending_cnt,
  output int         checked_cnt
);

  typedef struct packed {
    logic [7:0] rdata;
    logic       irq;
  } port_result_t;

  // predicted chip state
  logic [7:0]                  vram_img [VRAM_DEPTH];
  logic [7:0]                  cram_img [CRAM_DEPTH];
  logic [7:0]                  mode_img [16];
  logic [vcpi_pkg::ADDR_W-1:0] addr_img;
  logic [1:0]                  code_img;
  logic                        hi_byte_due;
  logic [7:0]                  buf_img;
  logic [7:0]                  status_img;
  logic                        irq_img;
  logic [7:0]                  line_cnt_img;

  port_result_t expected_q [$];

  // byte at the current address from the memory the code selects
  function automatic logic [7:0] fetch_byte();
    if (code_img == vcpi_pkg::CODE_CRAM) return cram_img[addr_img[4:0]];
    return vram_img[addr_img];
  endfunction

  // apply one host access to the predicted state and return its result
  function automatic port_result_t apply_access(logic [2:0] func, logic [7:0] wdata,
                                                logic [8:0] line);
    port_result_t res;
    logic         tall;
    logic [8:0]   vb_line;
    logic [8:0]   last_direct;
    logic [7:0]   jump_from;
    logic [7:0]   jump_to;
    res.rdata = 8'h00;
    case (func)
      vcpi_pkg::FUNC_CTRL_WR: begin
        if (hi_byte_due) begin
          addr_img = {wdata[5:0], addr_img[7:0]};
          code_img = wdata[7:6];
          if (code_img == vcpi_pkg::CODE_REG) mode_img[wdata[3:0]] = addr_img[7:0];
          else buf_img = fetch_byte();
          hi_byte_due = 1'b0;
        end else begin
          addr_img[7:0] = wdata;
          hi_byte_due = 1'b1;
        end
      end
      vcpi_pkg::FUNC_DATA_WR: begin
        hi_byte_due = 1'b0;
        buf_img = wdata;
        if (code_img != vcpi_pkg::CODE_REG) begin
          if (code_img == vcpi_pkg::CODE_CRAM) cram_img[addr_img[4:0]] = wdata;
          else vram_img[addr_img] = wdata;
          addr_img = addr_img + 1'b1;
        end
      end
      vcpi_pkg::FUNC_STATUS_RD: begin
        hi_byte_due = 1'b0;
        res.rdata = status_img;
        status_img = 8'h00;
        irq_img = 1'b0;
      end
      vcpi_pkg::FUNC_DATA_RD: begin
        hi_byte_due = 1'b0;
        res.rdata = buf_img;
        if (code_img != vcpi_pkg::CODE_REG) begin
          addr_img = addr_img + 1'b1;
          buf_img = fetch_byte();
        end
      end
      vcpi_pkg::FUNC_LINE_TICK: begin
        tall        = mode_img[0][2] && mode_img[1][4];
        vb_line     = tall ? vcpi_pkg::VB_LINE_TALL : vcpi_pkg::VB_LINE_SHORT;
        last_direct = tall ? vcpi_pkg::LAST_DIRECT_TALL : vcpi_pkg::LAST_DIRECT_SHORT;
        jump_from   = tall ? vcpi_pkg::JUMP_FROM_TALL : vcpi_pkg::JUMP_FROM_SHORT;
        jump_to     = tall ? vcpi_pkg::JUMP_TO_TALL : vcpi_pkg::JUMP_TO_SHORT;
        if (line == vb_line) begin
          if (mode_img[1][5]) irq_img = 1'b1;
          status_img = status_img | vcpi_pkg::STATUS_VBLANK;
        end
        // counter jumps back after the last direct line, wrapping in 8 bits
        if (line <= last_direct) line_cnt_img = line[7:0];
        else line_cnt_img = line[7:0] - jump_from + jump_to;
      end
      vcpi_pkg::FUNC_COUNT_RD: begin
        res.rdata = line_cnt_img;
      end
      default: begin
      end
    endcase
    res.irq = irq_img;
    return res;
  endfunction

  // compare finished transactions, then predict newly accepted ones
  always @(posedge clk) begin : watch
    port_result_t want;
    port_result_t got;
    int           errs;
    errs = 0;
    if (!rst_n) begin
      foreach (vram_img[i]) vram_img[i] = 8'h00;
      foreach (cram_img[i]) cram_img[i] = 8'h00;
      foreach (mode_img[i]) mode_img[i] = 8'h00;
      addr_img     = '0;
      code_img     = vcpi_pkg::CODE_VRAM_RD;
      hi_byte_due  = 1'b0;
      buf_img      = 8'h00;
      status_img   = 8'h00;
      irq_img      = 1'b0;
      line_cnt_img = 8'h00;
      expected_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $error("result with no transaction outstanding: rdata %0h irq %0b",
                 out_rdata, out_irq);
          errs++;
        end else begin
          want = expected_q.pop_front();
          got  = '{rdata: out_rdata, irq: out_irq};
          if (got.rdata !== want.rdata) begin
            $error("rdata mismatch: expected %0h, actual %0h", want.rdata, got.rdata);
            errs++;
          end
          if (got.irq !== want.irq) begin
            $error("irq mismatch: expected %0b, actual %0b", want.irq, got.irq);
            errs++;
          end
        end
        checked_cnt <= checked_cnt + 1;
      end
      if (in_valid && in_ready)
        expected_q.push_back(apply_access(in_func, in_wdata, in_scan_line));
    end
    fail_cnt    <= fail_cnt + errs;
    pending_cnt <= expected_q.size();
  end

endmodule

FILE: tb/video_chip_port_interface_top_tb.sv
// stimulus, clocking and verdict for the video chip port interface
module video_chip_port_interface_top_tb;

  localparam int unsigned RANDOM_ITEMS = 1000;
  localparam int unsigned DRAIN_EVERY  = 200;
  localparam int unsigned LIMIT_CYCLES = 600000;
  localparam int unsigned TAIL_CYCLES  = 8;
  // func codes with no defined access
  localparam logic [2:0] FUNC_SPARE_LO = 3'd6;
  localparam logic [2:0] FUNC_SPARE_HI = 3'd7;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [2:0] in_func;
  logic [7:0] in_wdata;
  logic [8:0] in_scan_line;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_rdata;
  logic       out_irq;

  int          fail_cnt;
  int          pending_cnt;
  int          checked_cnt;
  int unsigned sent_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned no_gap_left = 0;
  int unsigned ready_run = 0;
  int unsigned ready_stall = 0;

  always #6 clk = ~clk;

  video_chip_port_interface_top u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_func      (in_func),
    .in_wdata     (in_wdata),
    .in_scan_line (in_scan_line),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_rdata    (out_rdata),
    .out_irq      (out_irq)
  );

  vcpi_port_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_func      (in_func),
    .in_wdata     (in_wdata),
    .in_scan_line (in_scan_line),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_rdata    (out_rdata),
    .out_irq      (out_irq),
    .fail_cnt     (fail_cnt),
    .pending_cnt  (pending_cnt),
    .checked_cnt  (checked_cnt)
  );

  // result side backpressure: runs of ready, short stalls, now and then a long one
  always @(negedge clk) begin
    if (ready_run != 0) begin
      out_ready <= 1'b1;
      ready_run <= ready_run - 1;
    end else if (ready_stall != 0) begin
      out_ready   <= 1'b0;
      ready_stall <= ready_stall - 1;
    end else begin
      out_ready   <= 1'b1;
      ready_run   <= ($urandom_range(0, 19) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(0, 12);
      ready_stall <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                 : $urandom_range(1, 3);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("video_chip_port_interface_top verification failed");
      $finish;
    end
  end

  // one host transaction, preceded by a random idle gap
  task automatic send_access(input logic [2:0] func, input logic [7:0] wdata,
                             input logic [8:0] line);
    int unsigned gap;
    int unsigned pct;
    if (no_gap_left != 0) begin
      gap = 0;
      no_gap_left--;
    end else begin
      pct = $urandom_range(0, 99);
      if (pct < 3) no_gap_left = $urandom_range(20, 60);
      gap = (pct < 45) ? 0 : (pct < 90) ? $urandom_range(1, 3)
          : (pct < 98) ? $urandom_range(4, 10) : $urandom_range(20, 60);
    end
    if (gap != 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    in_func      <= func;
    in_wdata     <= wdata;
    in_scan_line <= line;
    do @(posedge clk); while (!in_ready);
    sent_cnt++;
  endtask

  // two control bytes: low address, then code and high address bits
  task automatic set_addr(input logic [vcpi_pkg::ADDR_W-1:0] addr, input logic [1:0] code);
    send_access(vcpi_pkg::FUNC_CTRL_WR, addr[7:0], 9'($urandom));
    send_access(vcpi_pkg::FUNC_CTRL_WR, {code, addr[13:8]}, 9'($urandom));
  endtask

  task automatic write_reg(input logic [3:0] idx, input logic [7:0] val);
    set_addr({2'($urandom), idx, val}, vcpi_pkg::CODE_REG);
  endtask

  // stop sending until every outstanding result has come back
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending_cnt == 0);
  endtask

  initial begin : stimulus
    int unsigned                 pick;
    int unsigned                 n;
    int unsigned                 target;
    int unsigned                 next_drain;
    logic [vcpi_pkg::ADDR_W-1:0] base;
    logic [8:0]                  line;

    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_func      = vcpi_pkg::FUNC_CTRL_WR;
    in_wdata     = 8'h00;
    in_scan_line = 9'h000;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // state right after reset
    send_access(vcpi_pkg::FUNC_STATUS_RD, 8'hFF, 9'h1FF);
    send_access(vcpi_pkg::FUNC_COUNT_RD, 8'h00, 9'h000);
    // video ram write and read across the address wrap
    set_addr(14'h3FFF, vcpi_pkg::CODE_VRAM_WR);
    send_access(vcpi_pkg::FUNC_DATA_WR, 8'hFF, 9'h000);
    send_access(vcpi_pkg::FUNC_DATA_WR, 8'h00, 9'h1FF);
    set_addr(14'h3FFF, vcpi_pkg::CODE_VRAM_RD);
    send_access(vcpi_pkg::FUNC_DATA_RD, 8'h00, 9'h000);
    send_access(vcpi_pkg::FUNC_DATA_RD, 8'h00, 9'h000);
    // colour ram at the top entry and its wrap to the first
    set_addr(14'h001F, vcpi_pkg::CODE_CRAM);
    send_access(vcpi_pkg::FUNC_DATA_WR, 8'hA5, 9'h000);
    send_access(vcpi_pkg::FUNC_DATA_RD, 8'h00, 9'h000);
    // tall mode with interrupt enabled, vblank line and out-of-range line
    write_reg(4'd0, 8'h04);
    write_reg(4'd1, 8'h30);
    send_access(vcpi_pkg::FUNC_LINE_TICK, 8'h00, vcpi_pkg::VB_LINE_TALL);
    send_access(vcpi_pkg::FUNC_STATUS_RD, 8'h00, 9'h000);
    send_access(vcpi_pkg::FUNC_LINE_TICK, 8'h00, 9'h1FF);
    send_access(vcpi_pkg::FUNC_COUNT_RD, 8'h00, 9'h000);
    // short mode without interrupt, then data access with the register code
    write_reg(4'd1, 8'h00);
    send_access(vcpi_pkg::FUNC_LINE_TICK, 8'h00, vcpi_pkg::VB_LINE_SHORT);
    send_access(vcpi_pkg::FUNC_DATA_WR, 8'h5A, 9'h000);
    send_access(vcpi_pkg::FUNC_DATA_RD, 8'h00, 9'h000);
    send_access(vcpi_pkg::FUNC_STATUS_RD, 8'h00, 9'h000);
    // undefined codes and a lone first control byte
    send_access(FUNC_SPARE_LO, 8'hFF, 9'h1FF);
    send_access(FUNC_SPARE_HI, 8'h00, 9'h000);
    send_access(vcpi_pkg::FUNC_CTRL_WR, 8'h3C, 9'h000);
    send_access(vcpi_pkg::FUNC_STATUS_RD, 8'h00, 9'h000);
    wait_drained();

    // random part: well-formed access sequences with some noise
    target     = sent_cnt + RANDOM_ITEMS;
    next_drain = sent_cnt + DRAIN_EVERY;
    while (sent_cnt < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        // video ram burst, sometimes near the wrap
        base = ($urandom_range(0, 3) == 0) ? 14'h3FF8 + 14'($urandom_range(0, 7))
                                           : 14'($urandom);
        set_addr(base, ($urandom_range(0, 1) != 0) ? vcpi_pkg::CODE_VRAM_WR
                                                   : vcpi_pkg::CODE_VRAM_RD);
        n = $urandom_range(1, 8);
        repeat (n)
          send_access(($urandom_range(0, 2) != 0) ? vcpi_pkg::FUNC_DATA_WR
                                                  : vcpi_pkg::FUNC_DATA_RD,
                      8'($urandom), 9'($urandom));
      end else if (pick < 45) begin
        // colour ram burst
        set_addr(14'($urandom), vcpi_pkg::CODE_CRAM);
        n = $urandom_range(1, 8);
        repeat (n)
          send_access(($urandom_range(0, 1) != 0) ? vcpi_pkg::FUNC_DATA_WR
                                                  : vcpi_pkg::FUNC_DATA_RD,
                      8'($urandom), 9'($urandom));
      end else if (pick < 60) begin
        // mode register write, mostly the two that steer line handling
        write_reg(($urandom_range(0, 1) != 0) ? 4'($urandom_range(0, 1)) : 4'($urandom),
                  8'($urandom));
      end else if (pick < 80) begin
        // run of scanlines around the interesting points
        case ($urandom_range(0, 6))
          0: line = 9'd188 + 9'($urandom_range(0, 6));
          1: line = 9'd220 + 9'($urandom_range(0, 6));
          2: line = 9'h0D8 + 9'($urandom_range(0, 5));
          3: line = 9'h0E8 + 9'($urandom_range(0, 5));
          4: line = 9'($urandom_range(0, 261));
          5: line = 9'($urandom_range(262, 511));
          default: line = 9'($urandom_range(250, 261));
        endcase
        n = $urandom_range(1, 6);
        repeat (n) begin
          send_access(vcpi_pkg::FUNC_LINE_TICK, 8'($urandom), line);
          if ($urandom_range(0, 1) != 0)
            send_access(vcpi_pkg::FUNC_COUNT_RD, 8'($urandom), 9'($urandom));
          line = line + 1'b1;
        end
        if ($urandom_range(0, 1) != 0)
          send_access(vcpi_pkg::FUNC_STATUS_RD, 8'($urandom), 9'($urandom));
      end else if (pick < 95) begin
        // any access, any field values
        send_access(3'($urandom), 8'($urandom), 9'($urandom));
      end else begin
        // broken control pair
        send_access(vcpi_pkg::FUNC_CTRL_WR, 8'($urandom), 9'($urandom));
        send_access(3'($urandom_range(1, 7)), 8'($urandom), 9'($urandom));
      end
      if (sent_cnt >= next_drain) begin
        wait_drained();
        next_drain = sent_cnt + DRAIN_EVERY;
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d host transactions, %0d results compared", sent_cnt, checked_cnt);
    $display("ram bursts with address wrap, register writes, both line modes, irq and noise");
    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("video_chip_port_interface_top verification clean");
    end else begin
      $display("video_chip_port_interface_top verification failed");
    end
    $finish;
  end

endmodule
